>>> hdl/sha1md_pkg.sv
// ============================================================================
// sha1md_pkg - shared types and constants for the SHA-1 digest core
// Holds the round constants, the initial hash value, the job passed from the
// front end to the compression engine and the state encodings.
// ============================================================================
package sha1md_pkg;

    localparam int BLOCK_WORDS = 16;
    localparam int HASH_WORDS  = 5;

    // Round number of the last round of the compression.
    localparam logic [6:0] LAST_ROUND = 7'd79;

    // Fill level at which the length field no longer fits in the block.
    localparam logic [5:0] LENGTH_AT = 6'd56;
    localparam logic [5:0] LAST_FILL = 6'd63;
    localparam logic [7:0] PAD_BYTE  = 8'h80;

    // Index of the final digest word.
    localparam logic [2:0] LAST_INDEX = 3'd4;

    localparam logic [31:0] ROUND_K [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };

    localparam logic [31:0] H_INIT [HASH_WORDS] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    // One 512-bit block for the compression engine. Word 0 holds the first
    // four bytes, big-endian. last_blk marks the block that ends a message.
    typedef struct packed {
        logic [BLOCK_WORDS-1:0][31:0] block;
        logic                         last_blk;
    } t_job;

    // One digest word on its way to the result queue.
    typedef struct packed {
        logic [2:0]  index;
        logic [31:0] word;
    } t_digest_beat;

    typedef enum logic [1:0] {
        FR_IDLE,
        FR_BLOCK,
        FR_PAD,
        FR_LEN
    } t_front_state;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_ROUND,
        BK_UPDATE,
        BK_EMIT
    } t_back_state;

endpackage

>>> hdl/sha1md_fifo.sv
// ============================================================================
// sha1md_fifo - small first-in first-out queue
// Register-based queue with the head entry always visible on o_data.
// ============================================================================
module sha1md_fifo #(
    parameter int DEPTH = 2,
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    output logic             o_full,
    input  logic [WIDTH-1:0] i_data,
    input  logic             i_pop,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    localparam int PTR_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [PTR_W-1:0] r_wr;
    logic [PTR_W-1:0] r_rd;
    logic [CNT_W-1:0] r_cnt;
    logic             push_ok;
    logic             pop_ok;

    assign o_full  = (r_cnt == CNT_W'(DEPTH));
    assign o_empty = (r_cnt == '0);
    assign o_data  = r_mem[r_rd];
    assign push_ok = i_push && !o_full;
    assign pop_ok  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr  <= '0;
            r_rd  <= '0;
            r_cnt <= '0;
        end else begin
            if (push_ok) begin
                r_wr <= (r_wr == PTR_W'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (pop_ok) begin
                r_rd <= (r_rd == PTR_W'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            if (push_ok && !pop_ok) begin
                r_cnt <= r_cnt + 1'b1;
            end else if (pop_ok && !push_ok) begin
                r_cnt <= r_cnt - 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (push_ok) begin
            r_mem[r_wr] <= i_data;
        end
    end

endmodule

>>> hdl/sha1md_front.sv
// ============================================================================
// sha1md_front - byte gathering and padding front end
// Packs message bytes big-endian into a 512-bit block, counts them and
// hands full and padded blocks to the compression engine as jobs.
// ============================================================================
module sha1md_front (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_push,
    output logic               o_full,
    input  logic [7:0]         i_data_byte,
    input  logic               i_byte_valid,
    input  logic               i_end_of_message,
    output logic               o_job_push,
    input  logic               i_job_full,
    output sha1md_pkg::t_job   o_job
);

    sha1md_pkg::t_front_state r_state;
    sha1md_pkg::t_front_state n_state;

    logic [sha1md_pkg::BLOCK_WORDS-1:0][31:0] r_block;
    logic [sha1md_pkg::BLOCK_WORDS-1:0][31:0] padded;
    logic [5:0]  r_fill;
    logic [5:0]  n_fill;
    logic [60:0] r_count;
    logic [60:0] n_count;
    logic        r_eom_pend;
    logic        n_eom_pend;
    logic        wr_byte;
    logic [63:0] bit_length;

    assign bit_length = {r_count, 3'b000};

    // Bytes before the fill point are kept, the fill point gets the pad
    // marker and everything after it is zero.
    always_comb begin
        logic [5:0] pos;
        pos = '0;
        for (int wi = 0; wi < sha1md_pkg::BLOCK_WORDS; wi++) begin
            for (int li = 0; li < 4; li++) begin
                pos = 6'(wi * 4 + li);
                if (pos < r_fill) begin
                    padded[wi][8*(3-li) +: 8] = r_block[wi][8*(3-li) +: 8];
                end else if (pos == r_fill) begin
                    padded[wi][8*(3-li) +: 8] = sha1md_pkg::PAD_BYTE;
                end else begin
                    padded[wi][8*(3-li) +: 8] = 8'h00;
                end
            end
        end
    end

    always_comb begin
        n_state        = r_state;
        n_fill         = r_fill;
        n_count        = r_count;
        n_eom_pend     = r_eom_pend;
        wr_byte        = 1'b0;
        o_job_push     = 1'b0;
        o_job.block    = r_block;
        o_job.last_blk = 1'b0;
        o_full         = (r_state != sha1md_pkg::FR_IDLE);

        unique case (r_state)
            sha1md_pkg::FR_IDLE: begin
                if (i_push) begin
                    if (i_byte_valid) begin
                        wr_byte = 1'b1;
                        n_count = r_count + 61'd1;
                        n_fill  = r_fill + 6'd1;
                        if (r_fill == sha1md_pkg::LAST_FILL) begin
                            n_state    = sha1md_pkg::FR_BLOCK;
                            n_eom_pend = i_end_of_message;
                        end else if (i_end_of_message) begin
                            n_state = sha1md_pkg::FR_PAD;
                        end
                    end else if (i_end_of_message) begin
                        n_state = sha1md_pkg::FR_PAD;
                    end
                end
            end
            sha1md_pkg::FR_BLOCK: begin
                o_job_push = !i_job_full;
                if (!i_job_full) begin
                    n_state = r_eom_pend ? sha1md_pkg::FR_PAD : sha1md_pkg::FR_IDLE;
                end
            end
            sha1md_pkg::FR_PAD: begin
                o_job_push  = !i_job_full;
                o_job.block = padded;
                if (r_fill < sha1md_pkg::LENGTH_AT) begin
                    o_job.block[14] = bit_length[63:32];
                    o_job.block[15] = bit_length[31:0];
                    o_job.last_blk  = 1'b1;
                end
                if (!i_job_full) begin
                    if (r_fill < sha1md_pkg::LENGTH_AT) begin
                        n_state = sha1md_pkg::FR_IDLE;
                        n_fill  = '0;
                        n_count = '0;
                    end else begin
                        n_state = sha1md_pkg::FR_LEN;
                    end
                end
            end
            sha1md_pkg::FR_LEN: begin
                o_job_push      = !i_job_full;
                o_job.block     = '0;
                o_job.block[14] = bit_length[63:32];
                o_job.block[15] = bit_length[31:0];
                o_job.last_blk  = 1'b1;
                if (!i_job_full) begin
                    n_state = sha1md_pkg::FR_IDLE;
                    n_fill  = '0;
                    n_count = '0;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state    <= sha1md_pkg::FR_IDLE;
            r_fill     <= '0;
            r_count    <= '0;
            r_eom_pend <= 1'b0;
        end else begin
            r_state    <= n_state;
            r_fill     <= n_fill;
            r_count    <= n_count;
            r_eom_pend <= n_eom_pend;
        end
    end

    always_ff @(posedge i_clk) begin
        if (wr_byte) begin
            r_block[r_fill[5:2]][{~r_fill[1:0], 3'b000} +: 8] <= i_data_byte;
        end
    end

endmodule

>>> hdl/sha1md_back.sv
// ============================================================================
// sha1md_back - SHA-1 compression engine
// Runs 80 rounds per block, one round per cycle, with a 16-word rolling
// message schedule, updates the chaining hash and emits the digest words.
// ============================================================================
module sha1md_back (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_job_empty,
    output logic                      o_job_pop,
    input  sha1md_pkg::t_job          i_job,
    output logic                      o_beat_push,
    input  logic                      i_beat_full,
    output sha1md_pkg::t_digest_beat  o_beat
);

    sha1md_pkg::t_back_state r_state;
    sha1md_pkg::t_back_state n_state;

    logic [sha1md_pkg::BLOCK_WORDS-1:0][31:0] r_w;
    logic [31:0] r_h [sha1md_pkg::HASH_WORDS];
    logic [31:0] r_a;
    logic [31:0] r_b;
    logic [31:0] r_c;
    logic [31:0] r_d;
    logic [31:0] r_e;
    logic [6:0]  r_round;
    logic [2:0]  r_idx;
    logic        r_last;

    logic        do_load;
    logic        do_round;
    logic        do_update;
    logic        do_emit;
    logic        emit_done;
    logic [31:0] f_val;
    logic [31:0] k_val;
    logic [31:0] temp;
    logic [31:0] w_mix;
    logic [31:0] w_next;

    always_comb begin
        priority if (r_round < 7'd20) begin
            f_val = (r_b & r_c) ^ (~r_b & r_d);
            k_val = sha1md_pkg::ROUND_K[0];
        end else if (r_round < 7'd40) begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1md_pkg::ROUND_K[1];
        end else if (r_round < 7'd60) begin
            f_val = (r_b & r_c) ^ (r_b & r_d) ^ (r_c & r_d);
            k_val = sha1md_pkg::ROUND_K[2];
        end else begin
            f_val = r_b ^ r_c ^ r_d;
            k_val = sha1md_pkg::ROUND_K[3];
        end
    end

    assign temp   = {r_a[26:0], r_a[31:27]} + f_val + r_e + k_val + r_w[0];
    assign w_mix  = r_w[13] ^ r_w[8] ^ r_w[2] ^ r_w[0];
    assign w_next = {w_mix[30:0], w_mix[31]};

    assign o_beat.index = r_idx;
    assign o_beat.word  = r_h[r_idx];

    always_comb begin
        n_state     = r_state;
        o_job_pop   = 1'b0;
        o_beat_push = 1'b0;
        do_load     = 1'b0;
        do_round    = 1'b0;
        do_update   = 1'b0;
        do_emit     = 1'b0;
        emit_done   = 1'b0;

        unique case (r_state)
            sha1md_pkg::BK_IDLE: begin
                if (!i_job_empty) begin
                    o_job_pop = 1'b1;
                    do_load   = 1'b1;
                    n_state   = sha1md_pkg::BK_ROUND;
                end
            end
            sha1md_pkg::BK_ROUND: begin
                do_round = 1'b1;
                if (r_round == sha1md_pkg::LAST_ROUND) begin
                    n_state = sha1md_pkg::BK_UPDATE;
                end
            end
            sha1md_pkg::BK_UPDATE: begin
                do_update = 1'b1;
                n_state   = r_last ? sha1md_pkg::BK_EMIT : sha1md_pkg::BK_IDLE;
            end
            sha1md_pkg::BK_EMIT: begin
                if (!i_beat_full) begin
                    o_beat_push = 1'b1;
                    do_emit     = 1'b1;
                    if (r_idx == sha1md_pkg::LAST_INDEX) begin
                        emit_done = 1'b1;
                        n_state   = sha1md_pkg::BK_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= sha1md_pkg::BK_IDLE;
            r_round <= '0;
            r_idx   <= '0;
            r_last  <= 1'b0;
            r_h     <= sha1md_pkg::H_INIT;
        end else begin
            r_state <= n_state;
            if (do_load) begin
                r_round <= '0;
                r_idx   <= '0;
                r_last  <= i_job.last_blk;
            end else if (do_round) begin
                r_round <= r_round + 7'd1;
            end
            if (do_update) begin
                r_h[0] <= r_h[0] + r_a;
                r_h[1] <= r_h[1] + r_b;
                r_h[2] <= r_h[2] + r_c;
                r_h[3] <= r_h[3] + r_d;
                r_h[4] <= r_h[4] + r_e;
            end else if (emit_done) begin
                r_h <= sha1md_pkg::H_INIT;
            end
            if (do_emit && !emit_done) begin
                r_idx <= r_idx + 3'd1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_load) begin
            r_w <= i_job.block;
            r_a <= r_h[0];
            r_b <= r_h[1];
            r_c <= r_h[2];
            r_d <= r_h[3];
            r_e <= r_h[4];
        end else if (do_round) begin
            r_w <= {w_next, r_w[sha1md_pkg::BLOCK_WORDS-1:1]};
            r_e <= r_d;
            r_d <= r_c;
            r_c <= {r_b[1:0], r_b[31:2]};
            r_b <= r_a;
            r_a <= temp;
        end
    end

endmodule

>>> hdl/sha1_message_digest_core.sv
// ============================================================================
// sha1_message_digest_core - streaming SHA-1 message digest
// Byte-stream SHA-1 with built-in padding; emits five digest words per
// message through a result queue.
// ============================================================================
// Each input beat carries an optional message byte and an optional end mark.
// A beat is taken while full is low; the beat that completes a 64-byte
// block is followed by the hand-off of that block to the job queue, and an
// end mark by the hand-off of one or two padded blocks. The compression
// engine runs one round per cycle: a load, 80 rounds and a hash update per
// block, and after the final block it writes the digest words, waiting
// while the result queue is full. The front end keeps gathering the next
// block while the engine works, holds full high during those hand-offs,
// and beyond them stalls only while the job queue is full.
// Five result beats, word_index 0 to 4 with last_word on the fifth, follow
// every end mark in order. After the digest the hash returns to its initial
// value, ready for the next message. JOB_DEPTH and OUT_DEPTH set the depth
// of the job queue and the result queue; both must be at least 2.
module sha1_message_digest_core #(
    parameter int JOB_DEPTH = 2,
    parameter int OUT_DEPTH = 8
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        push,
    output logic        full,
    input  logic [7:0]  i_data_byte,
    input  logic        i_byte_valid,
    input  logic        i_end_of_message,
    output logic        empty,
    input  logic        pop,
    output logic [31:0] o_digest_word,
    output logic [2:0]  o_word_index,
    output logic        o_last_word
);

    localparam int JOB_W  = $bits(sha1md_pkg::t_job);
    localparam int BEAT_W = $bits(sha1md_pkg::t_digest_beat);

    sha1md_pkg::t_job         job_in;
    sha1md_pkg::t_job         job_out;
    sha1md_pkg::t_digest_beat beat_in;
    sha1md_pkg::t_digest_beat beat_out;

    logic job_push;
    logic job_full;
    logic job_pop;
    logic job_empty;
    logic beat_push;
    logic beat_full;

    // Front end: gathers bytes, counts them and builds the padded blocks.
    sha1md_front u_front (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_push           (push),
        .o_full           (full),
        .i_data_byte      (i_data_byte),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .o_job_push       (job_push),
        .i_job_full       (job_full),
        .o_job            (job_in)
    );

    // Job queue decouples byte intake from the compression rounds.
    sha1md_fifo #(
        .DEPTH (JOB_DEPTH),
        .WIDTH (JOB_W)
    ) u_job_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (job_push),
        .o_full  (job_full),
        .i_data  (job_in),
        .i_pop   (job_pop),
        .o_empty (job_empty),
        .o_data  (job_out)
    );

    // Compression engine and digest emission.
    sha1md_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_job_empty (job_empty),
        .o_job_pop   (job_pop),
        .i_job       (job_out),
        .o_beat_push (beat_push),
        .i_beat_full (beat_full),
        .o_beat      (beat_in)
    );

    // Result queue holds digest words until the consumer pops them.
    sha1md_fifo #(
        .DEPTH (OUT_DEPTH),
        .WIDTH (BEAT_W)
    ) u_out_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (beat_push),
        .o_full  (beat_full),
        .i_data  (beat_in),
        .i_pop   (pop),
        .o_empty (empty),
        .o_data  (beat_out)
    );

    assign o_digest_word = beat_out.word;
    assign o_word_index  = beat_out.index;
    assign o_last_word   = (beat_out.index == sha1md_pkg::LAST_INDEX);

    // The front end never offers a block the job queue cannot take.
    a_job_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(job_push && job_full))
        else $error("job offered to a full job queue");

    // The engine never offers a digest word to a full result queue.
    a_beat_no_overflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(beat_push && beat_full))
        else $error("digest word offered to a full result queue");

    // Digest words leave in order: after a word other than the last, the
    // next waiting word carries the following index.
    a_word_order : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (pop && !empty && (o_word_index != sha1md_pkg::LAST_INDEX)) |=>
            (empty || (o_word_index == $past(o_word_index) + 3'd1)))
        else $error("digest words out of order");

    // The engine never pulls a job while the job queue is empty.
    a_job_no_underflow : assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(job_pop && job_empty))
        else $error("job popped from an empty job queue");

endmodule

>>> dv/sha1_message_digest_core_tb.sv
// ============================================================================
// sha1_message_digest_core_tb - self-checking bench for the SHA-1 digest core
// Streams byte messages into the core with random gaps on both queue sides,
// predicts the five digest words of each message with an independent SHA-1
// model and compares every result beat field by field.
// ============================================================================
`timescale 1ns / 100ps

// One expected digest beat, as it should appear on the result ports.
typedef struct {
    logic [31:0] word;
    logic [2:0]  index;
    logic        last;
} t_expected_beat;

// Scoreboard: holds a bit-exact SHA-1 model of the core and the digest
// beats that it still owes.
class sha1_digest_scoreboard;
    localparam logic [31:0] K_ROUND [4] = '{
        32'h5A827999, 32'h6ED9EBA1, 32'h8F1BBCDC, 32'hCA62C1D6
    };
    localparam logic [31:0] H_START [5] = '{
        32'h67452301, 32'hEFCDAB89, 32'h98BADCFE, 32'h10325476, 32'hC3D2E1F0
    };

    t_expected_beat digest_words_due[$];
    logic [31:0]  chain_hash[5];
    logic [7:0]   block_bytes[64];
    int unsigned  block_fill;
    logic [60:0]  msg_byte_count;
    int unsigned  mismatch_count;
    int unsigned  bytes_taken;
    int unsigned  messages_closed;
    int unsigned  words_checked;

    function new();
        chain_hash      = H_START;
        foreach (block_bytes[i]) block_bytes[i] = 8'h00;
        block_fill      = 0;
        msg_byte_count  = '0;
        mismatch_count  = 0;
        bytes_taken     = 0;
        messages_closed = 0;
        words_checked   = 0;
    endfunction

    function int unsigned pending();
        return digest_words_due.size();
    endfunction

    // 80-round compression of block_bytes into chain_hash.
    function void compress_block();
        logic [31:0] w[80];
        logic [31:0] a, b, c, d, e, f, t, x;
        int i;
        for (i = 0; i < 16; i++) begin
            w[i] = {block_bytes[4*i], block_bytes[4*i+1],
                    block_bytes[4*i+2], block_bytes[4*i+3]};
        end
        for (i = 16; i < 80; i++) begin
            x    = w[i-3] ^ w[i-8] ^ w[i-14] ^ w[i-16];
            w[i] = {x[30:0], x[31]};
        end
        a = chain_hash[0];
        b = chain_hash[1];
        c = chain_hash[2];
        d = chain_hash[3];
        e = chain_hash[4];
        for (i = 0; i < 80; i++) begin
            if (i < 20) begin
                f = (b & c) ^ (~b & d);
            end else if (i < 40 || i >= 60) begin
                f = b ^ c ^ d;
            end else begin
                f = (b & c) ^ (b & d) ^ (c & d);
            end
            t = {a[26:0], a[31:27]} + f + e + K_ROUND[i / 20] + w[i];
            e = d;
            d = c;
            c = {b[1:0], b[31:2]};
            b = a;
            a = t;
        end
        chain_hash[0] += a;
        chain_hash[1] += b;
        chain_hash[2] += c;
        chain_hash[3] += d;
        chain_hash[4] += e;
    endfunction

    // Called for every beat that the core accepts.
    function void absorb_beat(logic [7:0] data, logic valid, logic eom);
        logic [63:0]    bit_len;
        t_expected_beat beat;
        int i;
        if (valid) begin
            block_bytes[block_fill] = data;
            block_fill++;
            msg_byte_count = msg_byte_count + 61'd1;
            bytes_taken++;
            if (block_fill == 64) begin
                compress_block();
                block_fill = 0;
            end
        end
        if (eom) begin
            // Pad byte, zeros, then the length; spill into a second block
            // when fewer than eight bytes remain for the length field.
            block_bytes[block_fill] = 8'h80;
            for (i = block_fill + 1; i < 64; i++) block_bytes[i] = 8'h00;
            if (block_fill >= 56) begin
                compress_block();
                foreach (block_bytes[j]) block_bytes[j] = 8'h00;
            end
            bit_len = {msg_byte_count, 3'b000};
            for (i = 0; i < 8; i++) block_bytes[56+i] = bit_len[63-8*i -: 8];
            compress_block();
            for (i = 0; i < 5; i++) begin
                beat.word  = chain_hash[i];
                beat.index = 3'(i);
                beat.last  = (i == 4);
                digest_words_due.push_back(beat);
            end
            chain_hash     = H_START;
            block_fill     = 0;
            msg_byte_count = '0;
            messages_closed++;
        end
    endfunction

    // Called for every result beat that the bench pops.
    function void check_digest_beat(logic [31:0] word, logic [2:0] index, logic last);
        t_expected_beat due;
        if (digest_words_due.size() == 0) begin
            $error("unexpected digest beat: digest_word %h word_index %0d last_word %0b",
                   word, index, last);
            mismatch_count++;
        end else begin
            due = digest_words_due.pop_front();
            words_checked++;
            if (word !== due.word) begin
                $error("digest_word mismatch: expected %h, actual %h", due.word, word);
                mismatch_count++;
            end
            if (index !== due.index) begin
                $error("word_index mismatch: expected %0d, actual %0d", due.index, index);
                mismatch_count++;
            end
            if (last !== due.last) begin
                $error("last_word mismatch: expected %0b, actual %0b", due.last, last);
                mismatch_count++;
            end
        end
    endfunction
endclass

module sha1_message_digest_core_tb;

    localparam int          HALF_PERIOD_NS = 2;
    localparam int          RESET_CYCLES   = 4;
    // Target for the number of message bytes and end marks in random traffic.
    localparam int unsigned RANDOM_ITEMS   = 200;
    localparam int unsigned MIN_MESSAGES   = 4;
    // Long result-side hold-off; long enough for both queues of the core to
    // fill so that full rises while the sender keeps offering beats.
    localparam int          HOLD_CYCLES    = 600;
    localparam int          BURST_MESSAGES = 15;
    // Quiet cycles after the last digest word: more than one block time.
    localparam int          SETTLE_CYCLES  = 300;
    // A correct run ends far short of this limit on simulation time.
    localparam int          RUN_LIMIT_NS   = 2_000_000;

    logic        i_clk            = 1'b0;
    logic        i_rst_n          = 1'b0;
    logic        push             = 1'b0;
    logic        full;
    logic [7:0]  i_data_byte      = 8'h00;
    logic        i_byte_valid     = 1'b0;
    logic        i_end_of_message = 1'b0;
    logic        empty;
    logic        pop              = 1'b0;
    logic [31:0] o_digest_word;
    logic [2:0]  o_word_index;
    logic        o_last_word;

    sha1_digest_scoreboard sb = new();

    // Handshake between the sender and the result process for the long
    // hold-off; the result process clears it when it starts holding.
    bit          hold_results_req = 1'b0;
    int unsigned hold_count       = 0;
    int unsigned drain_pauses     = 0;
    int unsigned items_sent       = 0;

    sha1_message_digest_core dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .push             (push),
        .full             (full),
        .i_data_byte      (i_data_byte),
        .i_byte_valid     (i_byte_valid),
        .i_end_of_message (i_end_of_message),
        .empty            (empty),
        .pop              (pop),
        .o_digest_word    (o_digest_word),
        .o_word_index     (o_word_index),
        .o_last_word      (o_last_word)
    );

    always #(HALF_PERIOD_NS) i_clk = ~i_clk;

    // Offer one input beat after a gap of idle cycles and hold it until the
    // core takes it. Every call starts and ends at a rising edge, so push is
    // written once per time step: a gap lowers it, a back-to-back beat just
    // keeps it high with new payload.
    task automatic offer_beat(input logic [7:0] data, input logic valid,
                              input logic eom, input int unsigned gap);
        if (gap != 0) begin
            push <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        push             <= 1'b1;
        i_data_byte      <= data;
        i_byte_valid     <= valid;
        i_end_of_message <= eom;
        @(posedge i_clk);
        while (full) @(posedge i_clk);
        sb.absorb_beat(data, valid, eom);
        if (valid || eom) items_sent++;
    endtask

    // Send one whole message of random bytes. The end mark either rides on
    // the last byte or follows as a beat of its own; idle beats with random
    // junk on data_byte are mixed in when noisy is set.
    task automatic send_message(input int unsigned len, input bit noisy,
                                input bit no_gaps);
        bit          mark_on_byte;
        int unsigned gap;
        int unsigned n;
        mark_on_byte = (len != 0) && ($urandom_range(0, 1) == 1);
        for (n = 0; n < len; n++) begin
            gap = no_gaps ? 0 : $urandom_range(0, 17);
            if (noisy && $urandom_range(0, 7) == 0) begin
                offer_beat(8'($urandom_range(0, 255)), 1'b0, 1'b0, gap);
                gap = no_gaps ? 0 : $urandom_range(0, 17);
            end
            offer_beat(8'($urandom_range(0, 255)), 1'b1,
                       mark_on_byte && (n == len - 1), gap);
        end
        if (!mark_on_byte) begin
            gap = no_gaps ? 0 : $urandom_range(0, 17);
            offer_beat(8'($urandom_range(0, 255)), 1'b0, 1'b1, gap);
        end
    endtask

    // Hold the sender until every owed digest word has been popped.
    task automatic wait_for_drain();
        while (sb.pending() != 0) @(posedge i_clk);
        drain_pauses++;
    endtask

    // Message lengths lean toward small sizes and toward the padding
    // boundaries: 55 bytes just fits the length field, 56, 63 and 120 spill
    // the length into a second block, 64 ends exactly on a full block so that
    // padding starts a fresh one.
    function automatic int unsigned pick_length();
        int unsigned roll;
        int unsigned len;
        roll = $urandom_range(0, 99);
        if (roll < 55) begin
            len = $urandom_range(0, 12);
        end else if (roll < 80) begin
            case ($urandom_range(0, 4))
                0:       len = 55;
                1:       len = 56;
                2:       len = 63;
                3:       len = 64;
                default: len = 120;
            endcase
        end else begin
            len = $urandom_range(13, 130);
        end
        return len;
    endfunction

    // Result side: pop with a random wait before each beat, calm stretches
    // with no waiting at all, and one long hold-off on request.
    initial begin : result_side
        int unsigned gap;
        int unsigned calm_beats;
        calm_beats = 0;
        wait (i_rst_n === 1'b1);
        @(posedge i_clk);
        forever begin
            if (hold_results_req) begin
                hold_results_req = 1'b0;
                gap = HOLD_CYCLES;
                hold_count++;
            end else if (calm_beats != 0) begin
                calm_beats--;
                gap = 0;
            end else if ($urandom_range(0, 15) == 0) begin
                calm_beats = $urandom_range(10, 40);
                gap = 0;
            end else begin
                gap = $urandom_range(0, 17);
            end
            if (gap != 0) begin
                pop <= 1'b0;
                repeat (gap) @(posedge i_clk);
            end
            pop <= 1'b1;
            @(posedge i_clk);
            while (empty) @(posedge i_clk);
            sb.check_digest_beat(o_digest_word, o_word_index, o_last_word);
        end
    end

    // Stimulus and end of run.
    initial begin : input_side
        int unsigned m;
        int unsigned len;
        bit          no_gaps;

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed part. An idle beat with all data bits set must be
        // ignored; an end mark alone gives the digest of the empty string.
        offer_beat(8'hFF, 1'b0, 1'b0, 0);
        offer_beat(8'h00, 1'b0, 1'b1, 0);
        // A byte and the end mark in the same beat: byte first, then close.
        offer_beat(8'h00, 1'b1, 1'b1, 2);
        // A byte, then an end mark whose data bits must not be taken.
        offer_beat(8'hFF, 1'b1, 1'b0, 0);
        offer_beat(8'hFF, 1'b0, 1'b1, 0);
        offer_beat(8'h5A, 1'b0, 1'b0, 1);
        // The classic three-byte message, closed on its last byte.
        offer_beat(8'h61, 1'b1, 1'b0, 0);
        offer_beat(8'h62, 1'b1, 1'b0, 3);
        offer_beat(8'h63, 1'b1, 1'b1, 0);
        push <= 1'b0;
        wait_for_drain();

        // Random part: mostly well-formed messages, noisy now and then, some
        // of them sent without any gaps. After the second message, the result side
        // holds off while a burst of short messages backs the core up.
        // The byte counter's wrap after 2^61 bytes is out of reach here.
        m = 0;
        while (items_sent < RANDOM_ITEMS || m < MIN_MESSAGES) begin
            len     = pick_length();
            no_gaps = ($urandom_range(0, 3) == 0);
            send_message(len, $urandom_range(0, 2) == 0, no_gaps);
            m++;
            if (m == MIN_MESSAGES / 2) begin
                hold_results_req = 1'b1;
                repeat (BURST_MESSAGES) send_message($urandom_range(0, 3), 1'b0, 1'b1);
                push <= 1'b0;
                wait_for_drain();
            end
        end
        push <= 1'b0;

        // Let the last digest arrive, then stay quiet long enough for any
        // stray beat from the core to show up as unexpected.
        while (sb.pending() != 0) @(posedge i_clk);
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        $display("Summary: %0d messages, %0d message bytes, %0d digest words compared.",
                 sb.messages_closed, sb.bytes_taken, sb.words_checked);
        $display("Summary: %0d long result hold-off(s), %0d full drains by the sender.",
                 hold_count, drain_pauses);
        if (sb.mismatch_count == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    // Watchdog for a hung handshake.
    initial begin : watchdog
        #(RUN_LIMIT_NS);
        $display("CHECK FAILED");
        $finish;
    end

endmodule
